/* src/stog_pkg.sv */
// ----------------------------------------------------------------------------
// stog_pkg
// shared constants and types for the strided tensor offset generator
// ----------------------------------------------------------------------------
package stog_pkg;

	localparam int DIV_W     = 31;
	localparam int WORD_W    = 32;
	localparam int OFS_W     = 64;
	localparam int NUM_DIV   = 3;
	localparam int SHIFT_W   = 5;
	localparam int REG_IDX_W = 3;

	// register indexes of the write port
	typedef enum logic [REG_IDX_W-1:0] {
		REG_ROW_EXTENT    = 3'd0,
		REG_PLANE_SIZE    = 3'd1,
		REG_VOLUME_SIZE   = 3'd2,
		REG_STRIDE_INNER  = 3'd3,
		REG_STRIDE_ROW    = 3'd4,
		REG_STRIDE_PLANE  = 3'd5,
		REG_STRIDE_VOLUME = 3'd6
	} reg_idx_t;

	// divider constants per level: level 0 volume, 1 plane, 2 row
	typedef struct packed {
		logic [NUM_DIV-1:0][DIV_W-1:0]   d;
		logic [NUM_DIV-1:0][WORD_W-1:0]  m;
		logic [NUM_DIV-1:0][SHIFT_W-1:0] l;
	} div_cfg_t;

	typedef struct packed {
		logic [WORD_W-1:0] inner;
		logic [WORD_W-1:0] row;
		logic [WORD_W-1:0] plane;
		logic [WORD_W-1:0] volume;
	} stride_t;

endpackage

/* src/stog_magic.sv */
// ----------------------------------------------------------------------------
// stog_magic
// holds the divisors and derives their multiply-high constants, bit serial
// ----------------------------------------------------------------------------
module stog_magic
	import stog_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_index,
	input  logic [WORD_W-1:0]    wr_data,
	output div_cfg_t             cfg,
	output logic                 busy
);

	typedef enum logic {S_IDLE, S_RUN} state_t;

	state_t                          state_q;
	logic [NUM_DIV-1:0][DIV_W-1:0]   d_q;
	logic [NUM_DIV-1:0][WORD_W-1:0]  m_q;
	logic [NUM_DIV-1:0][SHIFT_W-1:0] l_q;
	logic [NUM_DIV-1:0]              pend_q;
	logic [1:0]                      sel_q;
	logic [DIV_W-1:0]                rem_q;
	logic [WORD_W-1:0]               quo_q;
	logic [SHIFT_W-1:0]              cnt_q;

	logic [1:0]         sel;
	logic [DIV_W-1:0]   dsel;
	logic [DIV_W-1:0]   dm1;
	logic [SHIFT_W-1:0] lsel;
	logic [WORD_W-1:0]  rem_init;
	logic [WORD_W-1:0]  rem2;
	logic               take;
	logic [WORD_W-1:0]  rem_nx;
	logic               div_wr;
	logic [1:0]         wsel;
	logic [NUM_DIV-1:0] pend_nx;

	always_comb begin
		priority if (pend_q[0]) sel = 2'd0;
		else if (pend_q[1]) sel = 2'd1;
		else sel = 2'd2;
	end

	// divisor words land in level order
	assign div_wr = wr_en && (wr_index <= REG_VOLUME_SIZE);
	assign wsel   = 2'(REG_VOLUME_SIZE - wr_index);

	always_comb begin
		pend_nx = pend_q;
		if (state_q == S_IDLE && pend_q != '0) pend_nx[sel] = 1'b0;
		if (div_wr) pend_nx[wsel] = 1'b1;
	end

	assign dsel = (state_q == S_RUN) ? d_q[sel_q] : d_q[sel];
	assign dm1  = dsel - DIV_W'(1);

	// ceil(log2 d) is the bit length of d - 1
	always_comb begin
		lsel = '0;
		for (int i = 0; i < DIV_W; i++) begin
			if (dm1[i]) lsel = SHIFT_W'(i + 1);
		end
	end

	assign rem_init = (WORD_W'(1) << lsel) - {1'b0, dsel};
	assign rem2     = {rem_q, 1'b0};
	assign take     = rem2 >= {1'b0, dsel};
	assign rem_nx   = take ? rem2 - {1'b0, dsel} : rem2;

	assign busy = (state_q == S_RUN) || (pend_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pend_q  <= '0;
			sel_q   <= '0;
			cnt_q   <= '0;
			for (int k = 0; k < NUM_DIV; k++) begin
				d_q[k] <= DIV_W'(1);
				m_q[k] <= WORD_W'(1);
				l_q[k] <= '0;
			end
		end else begin
			pend_q <= pend_nx;
			unique case (state_q)
				S_IDLE: begin
					if (pend_q != '0) begin
						sel_q       <= sel;
						l_q[sel]    <= lsel;
						rem_q       <= rem_init[DIV_W-1:0];
						quo_q       <= '0;
						cnt_q       <= '0;
						state_q     <= S_RUN;
					end
				end
				S_RUN: begin
					rem_q <= rem_nx[DIV_W-1:0];
					quo_q <= {quo_q[WORD_W-2:0], take};
					cnt_q <= cnt_q + SHIFT_W'(1);
					if (cnt_q == SHIFT_W'(WORD_W - 1)) begin
						m_q[sel_q] <= {quo_q[WORD_W-2:0], take} + WORD_W'(1);
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			// zero acts as one
			if (div_wr) begin
				d_q[wsel] <=
					(wr_data[DIV_W-1:0] == '0) ? DIV_W'(1) : wr_data[DIV_W-1:0];
			end
		end
	end

	assign cfg.d = d_q;
	assign cfg.m = m_q;
	assign cfg.l = l_q;

endmodule

/* src/stog_front.sv */
// ----------------------------------------------------------------------------
// stog_front
// takes index words and queues them ahead of the arithmetic pipeline
// ----------------------------------------------------------------------------
module stog_front
	import stog_pkg::*;
#(
	parameter int IW = 31
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [IW-1:0] idx_in,
	output logic          full,
	output logic          out_valid,
	output logic [IW-1:0] idx_out
);

	logic [IW-1:0] mem_q [2];
	logic          wptr_q;
	logic          rptr_q;
	logic [1:0]    cnt_q;
	logic          pop;

	// the back end never stalls, so any queued word leaves at once
	assign pop       = cnt_q != 2'd0;
	assign out_valid = pop;
	assign idx_out   = mem_q[rptr_q];
	assign full      = cnt_q == 2'd2;

	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= idx_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (pop) rptr_q <= ~rptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

/* src/stog_back.sv */
// ----------------------------------------------------------------------------
// stog_back
// three magic division levels then stride products and the offset sum
// ----------------------------------------------------------------------------
module stog_back
	import stog_pkg::*;
#(
	parameter int IW = 31
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [IW-1:0]     idx,
	input  div_cfg_t          dcfg,
	input  stride_t           strides,
	output logic              done,
	output logic [OFS_W-1:0]  byte_offset,
	output logic [DIV_W-1:0]  coord_inner,
	output logic [DIV_W-1:0]  coord_second,
	output logic [DIV_W-1:0]  coord_third,
	output logic [DIV_W-1:0]  coord_outer
);

	typedef struct packed {
		logic [IW-1:0]              n;
		logic [NUM_DIV-1:0][IW-1:0] c;
	} lane_t;

	lane_t              lane_in    [NUM_DIV];
	logic               valid_in   [NUM_DIV];
	lane_t              lane_s1    [NUM_DIV];
	lane_t              lane_s2    [NUM_DIV];
	lane_t              lane_s3    [NUM_DIV];
	logic               v_s1       [NUM_DIV];
	logic               v_s2       [NUM_DIV];
	logic               v_s3       [NUM_DIV];
	logic [IW+WORD_W-1:0] prod_s1  [NUM_DIV];
	logic [IW-1:0]      quo_s2     [NUM_DIV];

	assign lane_in[0].n  = idx;
	assign lane_in[0].c  = '0;
	assign valid_in[0]   = in_valid;

	for (genvar k = 0; k < NUM_DIV; k++) begin : g_lvl
		logic [IW-1:0]      hi;
		logic [IW:0]        sum;
		logic [IW:0]        qw;
		logic [IW+DIV_W-1:0] qd;
		lane_t              lane_nx;

		if (k > 0) begin : g_link
			assign lane_in[k]  = lane_s3[k-1];
			assign valid_in[k] = v_s3[k-1];
		end

		assign hi  = prod_s1[k][IW+WORD_W-1:WORD_W];
		assign sum = {1'b0, hi} + {1'b0, lane_s1[k].n};
		assign qw  = sum >> dcfg.l[k];
		assign qd  = quo_s2[k] * dcfg.d[k];

		// remainder goes on, quotient lands in its coordinate slot
		always_comb begin
			lane_nx      = lane_s2[k];
			lane_nx.n    = lane_s2[k].n - qd[IW-1:0];
			lane_nx.c[k] = quo_s2[k];
		end

		always_ff @(posedge clk) begin
			lane_s1[k] <= lane_in[k];
			prod_s1[k] <= lane_in[k].n * dcfg.m[k];
			lane_s2[k] <= lane_s1[k];
			quo_s2[k]  <= qw[IW-1:0];
			lane_s3[k] <= lane_nx;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s1[k] <= 1'b0;
				v_s2[k] <= 1'b0;
				v_s3[k] <= 1'b0;
			end else begin
				v_s1[k] <= valid_in[k];
				v_s2[k] <= v_s1[k];
				v_s3[k] <= v_s2[k];
			end
		end
	end

	lane_t             fin;
	logic [WORD_W-1:0] ci;
	logic [WORD_W-1:0] c2;
	logic [WORD_W-1:0] c3;
	logic [WORD_W-1:0] co;

	assign fin = lane_s3[NUM_DIV-1];
	assign ci  = WORD_W'(fin.n);
	assign c2  = WORD_W'(fin.c[2]);
	assign c3  = WORD_W'(fin.c[1]);
	assign co  = WORD_W'(fin.c[0]);

	logic [OFS_W-1:0] pi_s4, p2_s4, p3_s4, po_s4;
	logic [IW-1:0]    ci_s4, c2_s4, c3_s4, co_s4;
	logic [OFS_W-1:0] sa_s5, sb_s5;
	logic [IW-1:0]    ci_s5, c2_s5, c3_s5, co_s5;
	logic             v_s4, v_s5;
	logic [IW-1:0]    ci_s6, c2_s6, c3_s6, co_s6;

	always_ff @(posedge clk) begin
		pi_s4 <= ci * strides.inner;
		p2_s4 <= c2 * strides.row;
		p3_s4 <= c3 * strides.plane;
		po_s4 <= co * strides.volume;
		ci_s4 <= fin.n;
		c2_s4 <= fin.c[2];
		c3_s4 <= fin.c[1];
		co_s4 <= fin.c[0];
		sa_s5 <= pi_s4 + p2_s4;
		sb_s5 <= p3_s4 + po_s4;
		ci_s5 <= ci_s4;
		c2_s5 <= c2_s4;
		c3_s5 <= c3_s4;
		co_s5 <= co_s4;
		byte_offset <= sa_s5 + sb_s5;
		ci_s6 <= ci_s5;
		c2_s6 <= c2_s5;
		c3_s6 <= c3_s5;
		co_s6 <= co_s5;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s4 <= v_s3[NUM_DIV-1];
			v_s5 <= v_s4;
			done <= v_s5;
		end
	end

	assign coord_inner  = DIV_W'(ci_s6);
	assign coord_second = DIV_W'(c2_s6);
	assign coord_third  = DIV_W'(c3_s6);
	assign coord_outer  = DIV_W'(co_s6);

endmodule

/* src/strided_tensor_offset_generator_unit.sv */
// ----------------------------------------------------------------------------
// strided_tensor_offset_generator_unit
// splits a flat index into four tensor coordinates and a strided byte offset
// ----------------------------------------------------------------------------
// usage:
//   write divisors and strides on wr_en / wr_index / wr_data while idle.
//   a divisor write starts a bit-serial derivation of its multiply-high
//   constant, a load step then one quotient bit per step, and busy stays high
//   meanwhile. pending divisors are handled one after another.
//   a word is taken at a clock edge with start high and busy low.
//   each word enters a two-entry queue, then the back pipeline: three
//   division levels of three stages each, a product stage and two add stages.
//   done pulses for one cycle as the word leaves the last add stage, with
//   byte_offset and the coordinates valid in that cycle.
//   throughput is one word per cycle while busy is low, set by the fully pipelined back end.
//   the receiver cannot stall; results are dropped if not taken on done.
//   reset clears the queue, the pipeline valids, and loads divisors of one
//   and strides of zero with their constants ready, so busy is low at once.
// ----------------------------------------------------------------------------
module strided_tensor_offset_generator_unit
	import stog_pkg::*;
#(
	parameter int INDEX_BITS = 31
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [INDEX_BITS-1:0] flat_index,
	input  logic                  wr_en,
	input  logic [REG_IDX_W-1:0]  wr_index,
	input  logic [WORD_W-1:0]     wr_data,
	output logic                  done,
	output logic [OFS_W-1:0]      byte_offset,
	output logic [DIV_W-1:0]      coord_inner,
	output logic [DIV_W-1:0]      coord_second,
	output logic [DIV_W-1:0]      coord_third,
	output logic [DIV_W-1:0]      coord_outer
);

	div_cfg_t                dcfg;
	stride_t                 strides_q;
	logic                    magic_busy;
	logic                    q_full;
	logic                    q_valid;
	logic [INDEX_BITS-1:0]   q_idx;
	logic                    push;

	assign busy = magic_busy || q_full;
	assign push = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strides_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_STRIDE_INNER:  strides_q.inner  <= wr_data;
				REG_STRIDE_ROW:    strides_q.row    <= wr_data;
				REG_STRIDE_PLANE:  strides_q.plane  <= wr_data;
				REG_STRIDE_VOLUME: strides_q.volume <= wr_data;
				default: ;
			endcase
		end
	end

	stog_magic u_magic (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (dcfg),
		.busy     (magic_busy)
	);

	stog_front #(.IW(INDEX_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.idx_in    (flat_index),
		.full      (q_full),
		.out_valid (q_valid),
		.idx_out   (q_idx)
	);

	stog_back #(.IW(INDEX_BITS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (q_valid),
		.idx          (q_idx),
		.dcfg         (dcfg),
		.strides      (strides_q),
		.done         (done),
		.byte_offset  (byte_offset),
		.coord_inner  (coord_inner),
		.coord_second (coord_second),
		.coord_third  (coord_third),
		.coord_outer  (coord_outer)
	);

endmodule
